// ===== hdl/gfau_pkg.sv =====
// Shared types, codes and field multiply for the GF(2^8) arithmetic unit.
package gfau_pkg;

   localparam int ELEM_W = 8;
   localparam int EXP_W  = 16;
   localparam int POLY_W = 9;
   localparam int OP_W   = 3;
   localparam int CNT_W  = 3;

   localparam logic [OP_W-1:0] OP_ADD = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV = 3'd3;
   localparam logic [OP_W-1:0] OP_POW = 3'd4;

   // multiplier operand selection
   localparam logic [1:0] MSEL_SQR  = 2'd0;  // acc * acc
   localparam logic [1:0] MSEL_BASE = 2'd1;  // acc * base
   localparam logic [1:0] MSEL_DIVA = 2'd2;  // acc * a
   localparam logic [1:0] MSEL_AB   = 2'd3;  // a * b

   localparam logic [POLY_W-1:0] POLY_RESET = 9'h11D;
   localparam logic [ELEM_W-1:0] INV_EXP    = 8'd254;   // b^-1 = b^254
   localparam logic [ELEM_W-1:0] ELEM_ONE   = 8'd1;
   localparam logic [ELEM_W-1:0] ELEM_MAX   = 8'hFF;
   localparam logic [CNT_W-1:0]  CNT_LAST   = 3'd7;

   typedef struct packed {
      logic       load;      // latch request beat
      logic       init;      // set up square-and-multiply
      logic       acc_we;    // accumulator takes multiplier output
      logic [1:0] mul_sel;
      logic       step;      // next exponent bit
      logic       res_load;  // write output register
   } gfau_cmd_type;

   typedef struct packed {
      logic pow_needed;
      logic is_div;
      logic exp_msb;
      logic last;
   } gfau_stat_type;

   // carry-less multiply reduced by x^8 + taps
   function automatic logic [ELEM_W-1:0] gf_mul(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b,
                                                input logic [ELEM_W-1:0] taps);
      logic [ELEM_W-1:0] acc;
      logic [ELEM_W-1:0] sh;
      acc = '0;
      sh  = a;
      for (int i = 0; i < ELEM_W; i++) begin
         if (b[i]) begin
            acc = acc ^ sh;
         end
         if (sh[ELEM_W-1]) begin
            sh = {sh[ELEM_W-2:0], 1'b0} ^ taps;
         end else begin
            sh = {sh[ELEM_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== hdl/gfau_datapath.sv =====
// Operand, accumulator, exponent and output registers around one field multiplier.
module gfau_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [gfau_pkg::POLY_W-1:0]   csr_data,
   input  logic [gfau_pkg::OP_W-1:0]     req_operation,
   input  logic [gfau_pkg::ELEM_W-1:0]   req_operand_a,
   input  logic [gfau_pkg::EXP_W-1:0]    req_operand_b,
   input  gfau_pkg::gfau_cmd_type        cmd,
   output gfau_pkg::gfau_stat_type       stat,
   output logic [gfau_pkg::ELEM_W-1:0]   rsp_result,
   output logic                          rsp_divide_by_zero
);
   import gfau_pkg::*;

   logic [ELEM_W-1:0] taps_ff, taps_in;
   logic [OP_W-1:0]   op_ff;
   logic [ELEM_W-1:0] a_ff;
   logic [EXP_W-1:0]  b_ff;
   logic [ELEM_W-1:0] base_ff, base_in;
   logic [ELEM_W-1:0] acc_ff, acc_in;
   logic [ELEM_W-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ELEM_W-1:0] res_ff, res_in;
   logic              dz_ff, dz_in;

   logic [ELEM_W-1:0] b_lo;
   logic [ELEM_W:0]   fold_sum;
   logic [ELEM_W-1:0] fold_lo;
   logic [ELEM_W-1:0] exp_red;
   logic [ELEM_W-1:0] mul_x, mul_y, prod;
   logic              is_div, is_pow;

   assign b_lo   = b_ff[ELEM_W-1:0];
   assign is_div = (op_ff == OP_DIV);
   assign is_pow = (op_ff == OP_POW);

   // b mod 255: fold the two bytes, then the end-around carry
   assign fold_sum = {1'b0, b_ff[EXP_W-1:ELEM_W]} + {1'b0, b_ff[ELEM_W-1:0]};
   assign fold_lo  = fold_sum[ELEM_W-1:0] + {{(ELEM_W-1){1'b0}}, fold_sum[ELEM_W]};
   assign exp_red  = (fold_lo == ELEM_MAX) ? '0 : fold_lo;

   always_comb begin
      case (cmd.mul_sel)
         MSEL_SQR:  begin mul_x = acc_ff; mul_y = acc_ff;  end
         MSEL_BASE: begin mul_x = acc_ff; mul_y = base_ff; end
         MSEL_DIVA: begin mul_x = acc_ff; mul_y = a_ff;    end
         default:   begin mul_x = a_ff;   mul_y = b_lo;    end
      endcase
   end

   assign prod = gf_mul(mul_x, mul_y, taps_ff);

   assign taps_in = csr_we ? csr_data[ELEM_W-1:0] : taps_ff;

   always_comb begin
      base_in = base_ff;
      exp_in  = exp_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      if (cmd.init) begin
         base_in = is_div ? b_lo : a_ff;
         exp_in  = is_div ? INV_EXP : exp_red;
         cnt_in  = CNT_LAST;
         acc_in  = ELEM_ONE;
      end else begin
         if (cmd.acc_we) begin
            acc_in = prod;
         end
         if (cmd.step) begin
            exp_in = {exp_ff[ELEM_W-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_comb begin
      dz_in = is_div && (b_lo == '0);
      case (op_ff) inside
         OP_ADD, OP_SUB: res_in = a_ff ^ b_lo;
         OP_MUL:         res_in = prod;
         OP_DIV:         res_in = ((b_lo == '0) || (a_ff == '0)) ? '0 : acc_ff;
         OP_POW:         res_in = (b_ff == '0) ? ELEM_ONE :
                                  ((a_ff == '0) ? '0 : acc_ff);
         default:        res_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= POLY_RESET[ELEM_W-1:0];
      end else begin
         taps_ff <= taps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         a_ff  <= req_operand_a;
         b_ff  <= req_operand_b;
      end
      base_ff <= base_in;
      exp_ff  <= exp_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      if (cmd.res_load) begin
         res_ff <= res_in;
         dz_ff  <= dz_in;
      end
   end

   assign stat.is_div     = is_div;
   assign stat.pow_needed = (a_ff != '0) &&
                            ((is_div && (b_lo != '0)) || (is_pow && (b_ff != '0)));
   assign stat.exp_msb    = exp_ff[ELEM_W-1];
   assign stat.last       = (cnt_ff == '0);

   assign rsp_result         = res_ff;
   assign rsp_divide_by_zero = dz_ff;

endmodule

// ===== hdl/gfau_ctrl.sv =====
// Sequencer: decode, square-and-multiply over the exponent bits, result handoff.
module gfau_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  gfau_pkg::gfau_stat_type stat,
   output gfau_pkg::gfau_cmd_type  cmd
);
   import gfau_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SQR    = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_FIN    = 3'd4;
   localparam logic [2:0] ST_RES    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic [2:0] after_loop;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign after_loop = stat.is_div ? ST_FIN : ST_RES;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MSEL_AB;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.init = 1'b1;
            state_in = stat.pow_needed ? ST_SQR : ST_RES;
         end
         ST_SQR: begin
            cmd.acc_we  = 1'b1;
            cmd.mul_sel = MSEL_SQR;
            if (stat.exp_msb) begin
               state_in = ST_MUL;
            end else begin
               cmd.step = 1'b1;
               state_in = stat.last ? after_loop : ST_SQR;
            end
         end
         ST_MUL: begin
            cmd.acc_we  = 1'b1;
            cmd.mul_sel = MSEL_BASE;
            cmd.step    = 1'b1;
            state_in    = stat.last ? after_loop : ST_SQR;
         end
         ST_FIN: begin
            cmd.acc_we  = 1'b1;
            cmd.mul_sel = MSEL_DIVA;
            state_in    = ST_RES;
         end
         ST_RES: begin
            // hold here until the output register frees up
            if (out_free) begin
               cmd.res_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/gf256_arithmetic_unit_core.sv =====
// Top level of the GF(2^8) arithmetic unit: sequencer plus datapath.
//
//  channel  direction  beat contents
//  req      in         operation, operand_a, operand_b
//  rsp      out        result, divide_by_zero
//  csr      in         field_polynomial (low 8 bits are the reduction taps)
//
// One item at a time. Add, subtract, multiply and the special cases go from decode
// straight to the result state; power squares for each bit of the reduced exponent and
// multiplies by the base for each set bit; divide computes b^254 and one more product.
// The result goes valid in the same cycle as the next beat can be taken.
// The single field multiplier serves every product, one at a time.
// A finished result waits in the output register while the next item is accepted.
// Reset is synchronous; it restores the polynomial to 0x11D. csr is always ready.
module gf256_arithmetic_unit_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gfau_pkg::OP_W-1:0]     req_operation,
   input  logic [gfau_pkg::ELEM_W-1:0]   req_operand_a,
   input  logic [gfau_pkg::EXP_W-1:0]    req_operand_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gfau_pkg::ELEM_W-1:0]   rsp_result,
   output logic                          rsp_divide_by_zero,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gfau_pkg::POLY_W-1:0]   csr_field_polynomial
);
   import gfau_pkg::*;

   gfau_cmd_type  cmd;
   gfau_stat_type stat;

   assign csr_ready = 1'b1;

   gfau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gfau_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_valid),
      .csr_data           (csr_field_polynomial),
      .req_operation      (req_operation),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_result         (rsp_result),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   // busy right after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // divide by zero always carries a zero result
   a_dz_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_result == '0))
      else $error("divide by zero with nonzero result");

   // output register is never overwritten while a result waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");

   // init and accumulate never coincide
   a_init_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.init |-> (!cmd.acc_we && !cmd.step && !cmd.res_load))
      else $error("conflicting datapath commands");

endmodule
